@@ design/mtg_pkg.sv @@
// Shared constants, tables and types for the MIDI note sine tone generator.
// No dependencies; every other file of the block but mtg_fifo uses this package.
package mtg_pkg;

    // default configuration
    localparam int DEF_AUDIO_RATE       = 22050;
    localparam int DEF_PHASE_BITS       = 32;
    localparam int DEF_SINE_TABLE_DEPTH = 1024;

    // field widths
    localparam int NOTE_W   = 7;
    localparam int MS_W     = 16;
    localparam int VOL_W    = 7;
    localparam int COUNT_W  = 21;
    localparam int AMP_W    = 15;
    localparam int SAMPLE_W = 16;

    // command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [VOL_W-1:0]   VOL_MAX   = 7'd100;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // volume*16384/100 == (volume*4096)/25, reciprocal of 25 at 2^36
    localparam logic [31:0] AMP_RECIP = 32'd2748780544;
    localparam int          AMP_SHIFT = 24;

    // (rate*ms >> 3)/125 == rate*ms/1000, reciprocal of 125 at 2^36
    localparam logic [29:0] RATE_RECIP = 30'd549755814;
    localparam int          RATE_SHIFT = 36;

    // queues
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
    localparam int OUTQ_DEPTH = 8;
    localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

    // frequency of notes 60..71 in Hz, scaled by 2^24
    localparam logic [63:0] FREQ24 [12] = '{
        64'd4389348620, 64'd4650352872, 64'd4926877243, 64'd5219844609,
        64'd5530232722, 64'd5859077472, 64'd6207476348, 64'd6576592101,
        64'd6967656617, 64'd7381975040, 64'd7820930118, 64'd8285986825
    };

    // Q30 odd polynomial for the quarter wave
    localparam logic [63:0] SIN_COEF [7] = '{
        64'd1686629713, 64'd693598668, 64'd85569306, 64'd5026995,
        64'd172272, 64'd3864, 64'd61
    };
    localparam logic [63:0] Q30 = 64'd1073741824;

    typedef struct packed {
        logic               cmd;
        logic [COUNT_W-1:0] count;
        logic [AMP_W-1:0]   amp;
    } mtg_cmd_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       note_active;
        logic                       last_of_note;
    } mtg_result_t;

endpackage

@@ design/mtg_fifo.sv @@
// Small first-in first-out queue of registers with an occupancy count.
// Depends on nothing; used for the command queue and the result queue.
module mtg_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic [CW-1:0]    count,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data = mem[rd_ptr_reg];
    assign count   = count_reg;
    assign empty   = (count_reg == '0);

endmodule

@@ design/mtg_front.sv @@
// Front end: takes items, works out phase step, sample count and amplitude.
// Depends on mtg_pkg; feeds the command queue.
module mtg_front #(
    parameter int AUDIO_RATE = mtg_pkg::DEF_AUDIO_RATE,
    parameter int PHASE_BITS = mtg_pkg::DEF_PHASE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          cmd,
    input  logic [mtg_pkg::NOTE_W-1:0]    note,
    input  logic [mtg_pkg::MS_W-1:0]      duration_ms,
    input  logic [mtg_pkg::VOL_W-1:0]     volume,
    input  logic [mtg_pkg::CMDQ_CNT_W-1:0] q_count,
    output logic                          q_wr,
    output mtg_pkg::mtg_cmd_t             q_ent,
    output logic [PHASE_BITS-1:0]         q_step
);
    import mtg_pkg::*;

    localparam int AMP_PROD_W  = 39;
    localparam int RATE_PROD_W = 32;
    localparam int Q_PROD_W    = 59;
    localparam int RAW_CNT_W   = Q_PROD_W - RATE_SHIFT;
    localparam logic [15:0] RATE_C = 16'(AUDIO_RATE);

    // phase step per note, worked out at elaboration
    logic [PHASE_BITS-1:0] step_rom [128];

    for (genvar gi = 0; gi < 128; gi++)
    begin : g_step
        localparam int OCT = gi / 12;
        localparam int K   = gi % 12;
        localparam int E   = OCT + PHASE_BITS - 29;
        localparam int ESH = (E >= 0) ? E : 0;
        localparam int DSH = (E < 0) ? -E : 0;
        localparam logic [63:0] NUM  = FREQ24[K] << ESH;
        localparam logic [63:0] DEN  = 64'(AUDIO_RATE) << DSH;
        localparam logic [63:0] STEP = (NUM + DEN / 2) / DEN;
        assign step_rom[gi] = STEP[PHASE_BITS-1:0];
    end

    logic                   accept;
    logic [CMDQ_CNT_W:0]    credit_sum;
    logic [VOL_W-1:0]       vol_sat;

    logic                   v1_reg, cmd1_reg;
    logic [NOTE_W-1:0]      note1_reg;
    logic [AMP_PROD_W-1:0]  amp_prod1_reg, amp_prod1_next;
    logic [RATE_PROD_W-1:0] rate_prod1_reg, rate_prod1_next;

    logic                   v2_reg, cmd2_reg;
    logic [PHASE_BITS-1:0]  step2_reg;
    logic [AMP_W-1:0]       amp2_reg;
    logic [Q_PROD_W-1:0]    q_prod2_reg, q_prod2_next;
    logic [RAW_CNT_W-1:0]   cnt_raw;

    // credit: queue slots already taken plus items still in the two stages
    assign credit_sum = {1'b0, q_count} + (CMDQ_CNT_W + 1)'(v1_reg)
                        + (CMDQ_CNT_W + 1)'(v2_reg);
    assign full   = (credit_sum >= (CMDQ_CNT_W + 1)'(CMDQ_DEPTH));
    assign accept = push && !full;

    assign vol_sat         = (volume > VOL_MAX) ? VOL_MAX : volume;
    assign amp_prod1_next  = AMP_PROD_W'(vol_sat) * AMP_PROD_W'(AMP_RECIP);
    assign rate_prod1_next = RATE_PROD_W'(RATE_C) * RATE_PROD_W'(duration_ms);
    assign q_prod2_next    = Q_PROD_W'(rate_prod1_reg[RATE_PROD_W-1:3])
                             * Q_PROD_W'(RATE_RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd1_reg       <= cmd;
        note1_reg      <= note;
        amp_prod1_reg  <= amp_prod1_next;
        rate_prod1_reg <= rate_prod1_next;
        cmd2_reg       <= cmd1_reg;
        step2_reg      <= step_rom[note1_reg];
        amp2_reg       <= amp_prod1_reg[AMP_SHIFT +: AMP_W];
        q_prod2_reg    <= q_prod2_next;
    end

    assign cnt_raw = q_prod2_reg[Q_PROD_W-1:RATE_SHIFT];

    always_comb
    begin
        q_ent.cmd = cmd2_reg;
        q_ent.amp = amp2_reg;
        if (cnt_raw > RAW_CNT_W'(COUNT_MAX))
        begin
            q_ent.count = COUNT_MAX;
        end
        else
        begin
            q_ent.count = cnt_raw[COUNT_W-1:0];
        end
    end

    assign q_wr   = v2_reg;
    assign q_step = step2_reg;

endmodule

@@ design/mtg_back.sv @@
// Back end: note state, phase accumulator, sine ROM and amplitude scaling.
// Depends on mtg_pkg; drains the command queue and fills the result queue.
module mtg_back #(
    parameter int PHASE_BITS       = mtg_pkg::DEF_PHASE_BITS,
    parameter int SINE_TABLE_DEPTH = mtg_pkg::DEF_SINE_TABLE_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_empty,
    input  mtg_pkg::mtg_cmd_t              q_ent,
    input  logic [PHASE_BITS-1:0]          q_step,
    output logic                           q_rd,
    input  logic [mtg_pkg::OUTQ_CNT_W-1:0] out_count,
    output logic                           res_wr,
    output mtg_pkg::mtg_result_t           res
);
    import mtg_pkg::*;

    localparam int IDX_W = (SINE_TABLE_DEPTH > 1) ? $clog2(SINE_TABLE_DEPTH) : 1;
    localparam int PW    = PHASE_BITS + IDX_W + 1;

    // sine ROM contents, worked out at elaboration; read through a register
    logic signed [SAMPLE_W-1:0] sine_rom [SINE_TABLE_DEPTH];

    for (genvar gi = 0; gi < SINE_TABLE_DEPTH; gi++)
    begin : g_sine
        localparam logic [63:0] T    = (64'(gi) << 32) / 64'(SINE_TABLE_DEPTH);
        localparam logic [1:0]  QUAD = T[31:30];
        localparam logic [63:0] XR   = {34'd0, T[29:0]};
        localparam logic [63:0] X    = QUAD[0] ? (Q30 - XR) : XR;
        localparam logic [63:0] X2   = (X * X) >> 30;
        localparam logic [63:0] A5   = SIN_COEF[5] - ((X2 * SIN_COEF[6]) >> 30);
        localparam logic [63:0] A4   = SIN_COEF[4] - ((X2 * A5) >> 30);
        localparam logic [63:0] A3   = SIN_COEF[3] - ((X2 * A4) >> 30);
        localparam logic [63:0] A2   = SIN_COEF[2] - ((X2 * A3) >> 30);
        localparam logic [63:0] A1   = SIN_COEF[1] - ((X2 * A2) >> 30);
        localparam logic [63:0] A0   = SIN_COEF[0] - ((X2 * A1) >> 30);
        localparam logic [63:0] AX   = (X * A0) >> 30;
        localparam logic [63:0] MAG0 = (AX * 64'd32767 + (Q30 >> 1)) >> 30;
        localparam logic [63:0] MAG  = (MAG0 > 64'd32767) ? 64'd32767 : MAG0;
        localparam logic [15:0] ENT  = QUAD[1] ? 16'(64'd0 - MAG) : 16'(MAG);
        assign sine_rom[gi] = $signed(ENT);
    end

    logic                   is_tick, credit_ok;
    logic [OUTQ_CNT_W:0]    credit_sum;
    logic [PW-1:0]          idx_prod;

    logic [PHASE_BITS-1:0]  phase_reg, phase_next;
    logic [PHASE_BITS-1:0]  step_reg, step_next;
    logic [COUNT_W-1:0]     left_reg, left_next;
    logic [AMP_W-1:0]       amp_reg, amp_next;

    logic                   v1_reg, v2_reg, v3_reg;
    logic [IDX_W-1:0]       idx1_reg;
    logic                   act1_reg, last1_reg, act2_reg, last2_reg, act3_reg, last3_reg;
    logic [AMP_W-1:0]       amp1_reg, amp2_reg;
    logic signed [SAMPLE_W-1:0] sine2_reg;
    logic signed [31:0]     prod3_reg, prod3_next;
    logic signed [31:0]     biased;

    assign is_tick = (q_ent.cmd == CMD_TICK);
    // a tick issues only when the result queue has room for everything in flight
    assign credit_sum = {1'b0, out_count} + (OUTQ_CNT_W + 1)'(v1_reg)
                        + (OUTQ_CNT_W + 1)'(v2_reg) + (OUTQ_CNT_W + 1)'(v3_reg);
    assign credit_ok  = (credit_sum < (OUTQ_CNT_W + 1)'(OUTQ_DEPTH));
    assign q_rd       = !q_empty && (!is_tick || credit_ok);

    assign idx_prod = PW'(phase_reg) * PW'(SINE_TABLE_DEPTH);

    always_comb
    begin
        phase_next = phase_reg;
        step_next  = step_reg;
        left_next  = left_reg;
        amp_next   = amp_reg;
        if (q_rd)
        begin
            if (!is_tick)
            begin
                phase_next = '0;
                step_next  = q_step;
                left_next  = q_ent.count;
                amp_next   = q_ent.amp;
            end
            else if (left_reg != '0)
            begin
                phase_next = phase_reg + step_reg;
                left_next  = left_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            step_reg  <= '0;
            left_reg  <= '0;
            amp_reg   <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            step_reg  <= step_next;
            left_reg  <= left_next;
            amp_reg   <= amp_next;
            v1_reg    <= q_rd && is_tick;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
        end
    end

    assign prod3_next = 32'(sine2_reg) * 32'($signed({1'b0, amp2_reg}));

    always_ff @(posedge clk)
    begin
        idx1_reg  <= idx_prod[PHASE_BITS +: IDX_W];
        act1_reg  <= (left_reg != '0);
        last1_reg <= (left_reg == COUNT_W'(1));
        amp1_reg  <= amp_reg;
        sine2_reg <= sine_rom[idx1_reg];
        act2_reg  <= act1_reg;
        last2_reg <= last1_reg;
        amp2_reg  <= amp1_reg;
        prod3_reg <= prod3_next;
        act3_reg  <= act2_reg;
        last3_reg <= last2_reg;
    end

    // divide by 32768 rounding toward zero
    assign biased = prod3_reg + (prod3_reg[31] ? 32'sd32767 : 32'sd0);

    always_comb
    begin
        res.note_active  = act3_reg;
        res.last_of_note = act3_reg && last3_reg;
        res.sample       = act3_reg ? biased[30:15] : '0;
    end

    assign res_wr = v3_reg;

endmodule

@@ design/midi_note_sine_tone_generator.sv @@
// MIDI note sine tone generator: front end, command queue, synthesis back end, result queue.
// A tick passes the front-end stages, the command queue, the back-end stages and the result queue.
// Throughput: one item per cycle, tick or load, while full is low; the tick path holds the phase add,
// the sine table read and the amplitude multiply. A result that is not popped waits in an eight-entry
// queue; input stalls when it backs up. Reset (rst_n, asynchronous, low) clears note state, both queues
// and every stage valid. Depends on mtg_pkg, mtg_fifo, mtg_front and mtg_back.
module midi_note_sine_tone_generator #(
    parameter int AUDIO_RATE       = mtg_pkg::DEF_AUDIO_RATE,
    parameter int PHASE_BITS       = mtg_pkg::DEF_PHASE_BITS,
    parameter int SINE_TABLE_DEPTH = mtg_pkg::DEF_SINE_TABLE_DEPTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic                               cmd,
    input  logic [mtg_pkg::NOTE_W-1:0]         note,
    input  logic [mtg_pkg::MS_W-1:0]           duration_ms,
    input  logic [mtg_pkg::VOL_W-1:0]          volume,
    output logic                               empty,
    input  logic                               pop,
    output logic signed [mtg_pkg::SAMPLE_W-1:0] sample,
    output logic                               note_active,
    output logic                               last_of_note
);
    import mtg_pkg::*;

    localparam int CMDQ_W = $bits(mtg_cmd_t) + PHASE_BITS;
    localparam int OUTQ_W = $bits(mtg_result_t);

    logic                  fq_wr;
    mtg_cmd_t              fq_ent, bq_ent;
    logic [PHASE_BITS-1:0] fq_step, bq_step;
    logic [CMDQ_CNT_W-1:0] cq_count;
    logic                  cq_empty, cq_rd;
    logic [CMDQ_W-1:0]     cq_rd_data;

    logic                  res_wr;
    mtg_result_t           res_in, res_out;
    logic [OUTQ_W-1:0]     oq_rd_data;
    logic [OUTQ_CNT_W-1:0] oq_count;

    mtg_front #(
        .AUDIO_RATE  (AUDIO_RATE),
        .PHASE_BITS  (PHASE_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .cmd         (cmd),
        .note        (note),
        .duration_ms (duration_ms),
        .volume      (volume),
        .q_count     (cq_count),
        .q_wr        (fq_wr),
        .q_ent       (fq_ent),
        .q_step      (fq_step)
    );

    mtg_fifo #(
        .WIDTH (CMDQ_W),
        .DEPTH (CMDQ_DEPTH)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fq_wr),
        .wr_data ({fq_ent, fq_step}),
        .rd_en   (cq_rd),
        .rd_data (cq_rd_data),
        .count   (cq_count),
        .empty   (cq_empty)
    );

    assign bq_ent  = cq_rd_data[CMDQ_W-1:PHASE_BITS];
    assign bq_step = cq_rd_data[PHASE_BITS-1:0];

    mtg_back #(
        .PHASE_BITS       (PHASE_BITS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (cq_empty),
        .q_ent     (bq_ent),
        .q_step    (bq_step),
        .q_rd      (cq_rd),
        .out_count (oq_count),
        .res_wr    (res_wr),
        .res       (res_in)
    );

    mtg_fifo #(
        .WIDTH (OUTQ_W),
        .DEPTH (OUTQ_DEPTH)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_wr),
        .wr_data (res_in),
        .rd_en   (pop && !empty),
        .rd_data (oq_rd_data),
        .count   (oq_count),
        .empty   (empty)
    );

    assign res_out      = oq_rd_data;
    assign sample       = res_out.sample;
    assign note_active  = res_out.note_active;
    assign last_of_note = res_out.last_of_note;

endmodule

@@ design/mtg_checker.sv @@
// Port-level checks for the tone generator, bound to its top level.
// Depends on mtg_pkg and midi_note_sine_tone_generator.
module mtg_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                full,
    input logic                                empty,
    input logic                                pop,
    input logic signed [mtg_pkg::SAMPLE_W-1:0] sample,
    input logic                                note_active,
    input logic                                last_of_note
);
    import mtg_pkg::*;

    // idle tick gives silence and no end mark
    a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !note_active) |-> (sample == '0 && !last_of_note))
        else $error("idle item carries a non-zero sample or end mark");

    a_last_active: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && last_of_note) |-> note_active)
        else $error("end of note marked on an idle item");

    // amplitude never exceeds half scale
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (sample >= -16'sd16384 && sample <= 16'sd16384))
        else $error("sample out of range");

    // a sampled reset leaves both queues cleared
    a_reset_state: assert property (@(posedge clk)
        !rst_n |=> (empty && !full))
        else $error("queues not cleared by reset");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(sample) && $stable(note_active)
                              && $stable(last_of_note)))
        else $error("waiting item changed before it was taken");

endmodule

bind midi_note_sine_tone_generator mtg_checker u_mtg_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .full         (full),
    .empty        (empty),
    .pop          (pop),
    .sample       (sample),
    .note_active  (note_active),
    .last_of_note (last_of_note)
);

@@ sim/testbench.sv @@
// Self-checking bench for midi_note_sine_tone_generator: directed and random load and tick
// items, with gaps on both handshakes, checked against an in-bench tone predictor.
// Depends on mtg_pkg (widths, command codes, result type) and the generator RTL.
module testbench;

    localparam int AUDIO_RATE  = 22050;
    localparam int PHASE_BITS  = 32;
    localparam int SINE_DEPTH  = 1024;
    localparam int QUIET_LIMIT = 5000;
    localparam int RANDOM_ITEMS = 950;

    localparam longint unsigned NOTE_FREQ_Q24 [12] = '{
        64'd4389348620, 64'd4650352872, 64'd4926877243, 64'd5219844609,
        64'd5530232722, 64'd5859077472, 64'd6207476348, 64'd6576592101,
        64'd6967656617, 64'd7381975040, 64'd7820930118, 64'd8285986825
    };
    localparam longint unsigned SINE_POLY [7] = '{
        64'd1686629713, 64'd693598668, 64'd85569306, 64'd5026995,
        64'd172272, 64'd3864, 64'd61
    };
    localparam longint unsigned ONE_Q30 = 64'd1073741824;

    typedef struct {
        logic                          cmd;
        logic [mtg_pkg::NOTE_W-1:0]    note;
        logic [mtg_pkg::MS_W-1:0]      ms;
        logic [mtg_pkg::VOL_W-1:0]     vol;
        bit                            drain;
    } tone_item_t;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                push = 1'b0;
    logic                                full;
    logic                                cmd = mtg_pkg::CMD_TICK;
    logic [mtg_pkg::NOTE_W-1:0]          note = '0;
    logic [mtg_pkg::MS_W-1:0]            duration_ms = '0;
    logic [mtg_pkg::VOL_W-1:0]           volume = '0;
    logic                                empty;
    logic                                pop = 1'b0;
    logic signed [mtg_pkg::SAMPLE_W-1:0] sample;
    logic                                note_active;
    logic                                last_of_note;

    // predictor state
    logic signed [15:0]             sine_rom [SINE_DEPTH];
    logic [PHASE_BITS-1:0]          phase;
    logic [PHASE_BITS-1:0]          phase_inc;
    logic [mtg_pkg::COUNT_W-1:0]    samples_to_go;
    logic [mtg_pkg::AMP_W-1:0]      amplitude;

    tone_item_t             pending_items [$];
    mtg_pkg::mtg_result_t   expected_samples [$];
    int                     mismatches = 0;
    int                     send_idle = 0;
    int                     pop_idle = 0;
    int                     quiet_cycles = 0;
    bit                     steady = 1'b0;

    midi_note_sine_tone_generator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .cmd          (cmd),
        .note         (note),
        .duration_ms  (duration_ms),
        .volume       (volume),
        .empty        (empty),
        .pop          (pop),
        .sample       (sample),
        .note_active  (note_active),
        .last_of_note (last_of_note)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic signed [15:0] sine_value(int unsigned i);
        longint unsigned t, quad, x, x2, acc, mag;
        logic signed [15:0] s;
        t = i;
        t = (t << 32) / SINE_DEPTH;
        quad = (t >> 30) & 64'd3;
        x = t & (ONE_Q30 - 1);
        if (quad[0])
            x = ONE_Q30 - x;
        x2 = (x * x) >> 30;
        acc = SINE_POLY[6];
        for (int j = 5; j >= 0; j--)
            acc = SINE_POLY[j] - ((x2 * acc) >> 30);
        acc = (x * acc) >> 30;
        mag = (acc * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
        if (mag > 64'd32767)
            mag = 64'd32767;
        s = mag[15:0];
        return (quad >= 2) ? -s : s;
    endfunction

    function automatic logic [PHASE_BITS-1:0] step_for_note(int unsigned n);
        longint unsigned num, den, stp;
        int e;
        e = int'(n / 12) + PHASE_BITS - 29;
        if (e >= 0)
        begin
            num = NOTE_FREQ_Q24[n % 12] << e;
            den = AUDIO_RATE;
        end
        else
        begin
            num = NOTE_FREQ_Q24[n % 12];
            den = longint'(AUDIO_RATE) << (-e);
        end
        stp = (num + den / 2) / den;
        return stp[PHASE_BITS-1:0];
    endfunction

    function automatic int unsigned sample_count(int unsigned ms);
        longint unsigned c;
        c = (longint'(AUDIO_RATE) * ms) / 1000;
        if (c > 64'd2097151)
            c = 64'd2097151;
        return c[31:0];
    endfunction

    // advance the tone model by one accepted item
    task automatic play_item(logic c, logic [6:0] n, logic [15:0] ms, logic [6:0] v);
        mtg_pkg::mtg_result_t r;
        int unsigned vol_sat;
        int unsigned cnt_full;
        int unsigned amp_full;
        longint unsigned idx;
        int prod;
        int q;
        if (c == mtg_pkg::CMD_LOAD)
        begin
            vol_sat = (v > 7'd100) ? 100 : v;
            phase = '0;
            phase_inc = step_for_note(n);
            cnt_full = sample_count(ms);
            samples_to_go = cnt_full[mtg_pkg::COUNT_W-1:0];
            amp_full = (vol_sat * 16384) / 100;
            amplitude = amp_full[mtg_pkg::AMP_W-1:0];
        end
        else
        begin
            if (samples_to_go == 0)
            begin
                r.sample = '0;
                r.note_active = 1'b0;
                r.last_of_note = 1'b0;
            end
            else
            begin
                idx = (longint'(phase) * SINE_DEPTH) >> PHASE_BITS;
                prod = int'(sine_rom[idx]) * int'({1'b0, amplitude});
                q = prod / 32768;     // truncates toward zero
                r.sample = q[15:0];
                r.note_active = 1'b1;
                r.last_of_note = (samples_to_go == 1);
                phase = phase + phase_inc;
                samples_to_go = samples_to_go - 1'b1;
            end
            expected_samples.push_back(r);
        end
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 149) == 0)
            steady = !steady;
        if (steady || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    task automatic add_item(logic c, int unsigned n, int unsigned ms, int unsigned v,
                            bit drain = 1'b0);
        tone_item_t it;
        it.cmd = c;
        it.note = n[mtg_pkg::NOTE_W-1:0];
        it.ms = ms[mtg_pkg::MS_W-1:0];
        it.vol = v[mtg_pkg::VOL_W-1:0];
        it.drain = drain;
        pending_items.push_back(it);
    endtask

    task automatic add_tick();
        add_item(mtg_pkg::CMD_TICK, $urandom_range(0, 127), $urandom_range(0, 65535),
                 $urandom_range(0, 127));
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        tone_item_t it;
        if (!rst_n)
        begin
            push <= 1'b0;
            send_idle = 0;
        end
        else
        begin
            if (push && !full)
                play_item(cmd, note, duration_ms, volume);
            if (push && full)
                ;
            else if (send_idle > 0)
            begin
                send_idle--;
                push <= 1'b0;
            end
            else if (pending_items.size() != 0 &&
                     (!pending_items[0].drain || expected_samples.size() == 0))
            begin
                it = pending_items.pop_front();
                push <= 1'b1;
                cmd <= it.cmd;
                note <= it.note;
                duration_ms <= it.ms;
                volume <= it.vol;
                send_idle = gap_len();
            end
            else
                push <= 1'b0;
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        mtg_pkg::mtg_result_t want;
        if (!rst_n)
        begin
            pop <= 1'b0;
            pop_idle = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_samples.size() == 0)
                begin
                    $error("sample %0d arrived with nothing outstanding", sample);
                    mismatches++;
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (sample !== want.sample)
                    begin
                        $error("sample: expected %0d, got %0d", want.sample, sample);
                        mismatches++;
                    end
                    if (note_active !== want.note_active)
                    begin
                        $error("note_active: expected %0b, got %0b",
                               want.note_active, note_active);
                        mismatches++;
                    end
                    if (last_of_note !== want.last_of_note)
                    begin
                        $error("last_of_note: expected %0b, got %0b",
                               want.last_of_note, last_of_note);
                        mismatches++;
                    end
                end
            end
            if (pop_idle > 0)
            begin
                pop_idle--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
                pop_idle = gap_len();
            end
        end
    end

    // watchdog: trips on a long run with no handshake on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned total, ms, cnt, ticks, r;
        bit drained;
        for (int i = 0; i < SINE_DEPTH; i++)
            sine_rom[i] = sine_value(i);
        phase = '0;
        phase_inc = '0;
        samples_to_go = '0;
        amplitude = '0;

        // directed: idle ticks, zero duration, extremes, saturated volume, replacement
        add_item(mtg_pkg::CMD_TICK, 127, 65535, 127);
        add_item(mtg_pkg::CMD_LOAD, 0, 0, 0);
        add_item(mtg_pkg::CMD_TICK, 0, 0, 0);
        add_item(mtg_pkg::CMD_LOAD, 127, 65535, 127);
        repeat (3) add_tick();
        add_item(mtg_pkg::CMD_LOAD, 69, 1, 100);
        repeat (2) add_tick();
        add_item(mtg_pkg::CMD_LOAD, 60, 2, 0);
        repeat (2) add_tick();
        add_item(mtg_pkg::CMD_LOAD, 0, 1, 1, 1'b1);
        repeat (2) add_tick();
        add_item(mtg_pkg::CMD_LOAD, 100, 1, 101);
        repeat (3) add_tick();

        // random: mostly whole notes with random content, some cut short, some noise
        total = 0;
        drained = 1'b0;
        while (total < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
            begin
                repeat ($urandom_range(1, 6))
                begin
                    add_item(1'($urandom_range(0, 1)), $urandom_range(0, 127),
                             $urandom_range(0, 65535), $urandom_range(0, 127));
                    total++;
                end
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 60)
                    ms = $urandom_range(0, 2);
                else if (r < 90)
                    ms = $urandom_range(3, 4);
                else
                    ms = $urandom_range(0, 65535);
                cnt = sample_count(ms);
                if (cnt > 150)
                    ticks = $urandom_range(1, 40);
                else if ($urandom_range(0, 3) == 0)
                    ticks = $urandom_range(0, cnt);
                else
                    ticks = cnt + $urandom_range(0, 3);
                add_item(mtg_pkg::CMD_LOAD, $urandom_range(0, 127), ms,
                         $urandom_range(0, 127), !drained || $urandom_range(0, 15) == 0);
                drained = 1'b1;
                repeat (ticks) add_tick();
                total += ticks + 1;
            end
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || push)
            @(posedge clk);
        while (expected_samples.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ sim.f @@
design/mtg_pkg.sv
design/mtg_fifo.sv
design/mtg_front.sv
design/mtg_back.sv
design/midi_note_sine_tone_generator.sv
design/mtg_checker.sv
sim/testbench.sv
